### design/spq_pkg.sv
// shared types and constants for the sorted priority queue
`default_nettype none

package spq_pkg;

    // queue depth and field widths
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int PRIO_W   = 16;
    localparam int STAT_W   = 2;
    localparam int OCC_W    = 5;

    // operation codes on the kind field
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] item_data;
        logic        [PRIO_W-1:0] item_priority;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_data;
        logic        [STAT_W-1:0] status;
        logic        [OCC_W-1:0]  occupancy;
    } t_out_item;

    // datapath command issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH,
        OP_PUSH_FULL,
        OP_POP,
        OP_POP_EMPTY
    } t_op;

    // datapath status seen by the controller
    typedef struct packed {
        logic empty;
        logic full;
    } t_dp_stat;

    typedef enum logic {
        ST_IDLE,
        ST_HOLD
    } t_state;

endpackage

`default_nettype wire

### design/sorted_priority_queue.sv
// top level of the sorted priority queue: controller plus cell-array datapath
//
// usage
//   input channel (i_in_valid / o_in_ready / i_in_item) carries one operation
//   per beat: kind 0 enqueues item_data at item_priority, kind 1 dequeues the
//   entry with the lowest priority value; equal priorities leave in arrival order
//   output channel (o_out_valid / i_out_ready / o_out_item) returns exactly one
//   result beat per operation: out_data (dequeued word, else zero), status
//   (ok, dequeue on empty, enqueue on full) and occupancy after the operation
//   timing: the result is registered and valid in the cycle after the input beat is accepted
//   throughput: one operation per cycle while i_out_ready is high; the cell array
//   compares every held priority against the new one and shifts cells in the same
//   cycle, and the single output register is refilled in the cycle it is emptied
//   stall: while a result beat waits with i_out_ready low, o_in_ready is low and
//   the queue contents stay frozen; no beat is lost or repeated
//   reset: synchronous, active low; the queue comes up empty with no result
//   pending, and cell contents are don't-care until written
`default_nettype none

module sorted_priority_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire spq_pkg::t_in_item   i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output spq_pkg::t_out_item       o_out_item
);

    // command and status between the controller and the datapath
    spq_pkg::t_op      op;
    spq_pkg::t_dp_stat dp_stat;

    // handshake control and operation decode
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_in_item.kind),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_op        (op)
    );

    // sorted cells, count and result register
    spq_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op),
        .i_item  (i_in_item),
        .o_stat  (dp_stat),
        .o_res   (o_out_item)
    );

endmodule

`default_nettype wire

### design/spq_ctrl.sv
// controller: handshake state machine and operation decode
`default_nettype none

module spq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic            i_kind,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire spq_pkg::t_dp_stat i_stat,
    output spq_pkg::t_op         o_op
);

    spq_pkg::t_state r_state;
    spq_pkg::t_state n_state;
    logic            accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_out_valid = 1'b0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            spq_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            spq_pkg::ST_HOLD: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready;
                if (i_out_ready) begin
                    n_state = spq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = spq_pkg::ST_IDLE;
            end
        endcase

        accept = i_in_valid && o_in_ready;
        o_op   = spq_pkg::OP_NONE;
        if (accept) begin
            n_state = spq_pkg::ST_HOLD;
            if (i_kind == spq_pkg::KIND_DEQ) begin
                o_op = i_stat.empty ? spq_pkg::OP_POP_EMPTY : spq_pkg::OP_POP;
            end else begin
                o_op = i_stat.full ? spq_pkg::OP_PUSH_FULL : spq_pkg::OP_PUSH;
            end
        end
    end

    a_accept_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted item produced no result beat");

    a_op_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op != spq_pkg::OP_NONE) |-> accept)
        else $error("datapath command without accepted item");

    a_hold_until_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result beat dropped before it was taken");

endmodule

`default_nettype wire

### design/spq_datapath.sv
// datapath: sorted cell array, entry count and result register
`default_nettype none

module spq_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire spq_pkg::t_op      i_op,
    input  wire spq_pkg::t_in_item i_item,
    output spq_pkg::t_dp_stat      o_stat,
    output spq_pkg::t_out_item     o_res
);

    logic [spq_pkg::DATA_W-1:0] r_data [spq_pkg::CAPACITY];
    logic [spq_pkg::DATA_W-1:0] n_data [spq_pkg::CAPACITY];
    logic [spq_pkg::PRIO_W-1:0] r_prio [spq_pkg::CAPACITY];
    logic [spq_pkg::PRIO_W-1:0] n_prio [spq_pkg::CAPACITY];
    logic [spq_pkg::CNT_W-1:0]  r_count;
    logic [spq_pkg::CNT_W-1:0]  n_count;
    logic [spq_pkg::CAPACITY-1:0] at_after;
    logic                         sorted;
    spq_pkg::t_out_item           r_res;
    spq_pkg::t_out_item           n_res;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
    assign o_res        = r_res;

    // a cell is at or after the insertion point if empty or strictly greater
    always_comb begin
        for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
            at_after[i] = (spq_pkg::CNT_W'(i) >= r_count) ||
                          (r_prio[i] > i_item.item_priority);
        end
    end

    always_comb begin
        n_count = r_count;
        for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
            n_data[i] = r_data[i];
            n_prio[i] = r_prio[i];
        end
        case (i_op)
            spq_pkg::OP_PUSH: begin
                n_count = r_count + 1'b1;
                if (at_after[0]) begin
                    n_data[0] = i_item.item_data;
                    n_prio[0] = i_item.item_priority;
                end
                for (int i = 1; i < spq_pkg::CAPACITY; i++) begin
                    if (at_after[i]) begin
                        if (at_after[i-1]) begin
                            n_data[i] = r_data[i-1];
                            n_prio[i] = r_prio[i-1];
                        end else begin
                            n_data[i] = i_item.item_data;
                            n_prio[i] = i_item.item_priority;
                        end
                    end
                end
            end
            spq_pkg::OP_POP: begin
                n_count = r_count - 1'b1;
                for (int i = 0; i < spq_pkg::CAPACITY - 1; i++) begin
                    n_data[i] = r_data[i+1];
                    n_prio[i] = r_prio[i+1];
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_res           = r_res;
        n_res.out_data  = '0;
        n_res.occupancy = spq_pkg::OCC_W'(n_count);
        n_res.status    = spq_pkg::STAT_OK;
        case (i_op)
            spq_pkg::OP_POP:       n_res.out_data = r_data[0];
            spq_pkg::OP_POP_EMPTY: n_res.status   = spq_pkg::STAT_EMPTY;
            spq_pkg::OP_PUSH_FULL: n_res.status   = spq_pkg::STAT_FULL;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_prio <= n_prio;
        if (i_op != spq_pkg::OP_NONE) begin
            r_res <= n_res;
        end
    end

    // occupied cells keep non-decreasing priority
    always_comb begin
        sorted = 1'b1;
        for (int i = 1; i < spq_pkg::CAPACITY; i++) begin
            if ((spq_pkg::CNT_W'(i) < r_count) && (r_prio[i] < r_prio[i-1])) begin
                sorted = 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spq_pkg::CNT_W'(spq_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sorted)
        else $error("cell array out of priority order");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == spq_pkg::OP_PUSH) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not grow the count");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == spq_pkg::OP_PUSH_FULL || i_op == spq_pkg::OP_POP_EMPTY)
        |=> $stable(r_count))
        else $error("rejected operation changed the count");

endmodule

`default_nettype wire
